@@ rtl/lpct_pkg.sv @@
// Shared types, codes and constants for the linear-probe count table.
package lpct_pkg;

   localparam int unsigned TABLE_SIZE = 1024;
   localparam int unsigned KEY_W      = 28;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned KEY_OFFSET = 100000000;
   // Depth by which the most negative key falls below zero after the offset.
   localparam int unsigned NEG_SPAN   = (1 << (KEY_W - 1)) - KEY_OFFSET;
   // Width of the biased, always non-negative key.
   localparam int unsigned HASH_W     = 29;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } slot_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;    // capture request
      logic hash_mul;    // hash step 1: bias and reciprocal multiply
      logic hash_scale;  // hash step 2: quotient times table size
      logic hash_fold;   // hash step 3: remainder into slot index
      logic clr_write;   // clear-pass write of one slot
      logic rd;          // read slot at index
      logic probe_next;  // move to next slot
      logic commit;      // update slot and load response
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clr_last;    // clear pass at last slot
      logic hit;         // slot read is empty or holds the key
      logic probe_last;  // current probe is the last allowed
   } sts_type;

endpackage

@@ rtl/lpct_hash.sv @@
// Home-slot unit: (key + offset) mod table size over three steps.
module lpct_hash #(
   parameter int unsigned TABLE_SIZE = lpct_pkg::TABLE_SIZE,
   localparam int unsigned IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
   input  logic                       clock,
   input  lpct_pkg::cmd_type          cmd,
   input  logic [lpct_pkg::KEY_W-1:0] key,
   output logic [IDX_W-1:0]           slot
);

   localparam int unsigned HW = lpct_pkg::HASH_W;
   // Extra multiple of the table size keeps the biased key non-negative.
   localparam int unsigned KEY_BIAS = lpct_pkg::KEY_OFFSET +
      TABLE_SIZE * ((lpct_pkg::NEG_SPAN + TABLE_SIZE - 1) / TABLE_SIZE);
   localparam logic [HW-1:0] RECIP  = HW'((64'd1 << HW) / 64'(TABLE_SIZE));
   localparam logic [16:0]   TSIZE  = 17'(TABLE_SIZE);

   logic [HW:0]       biased;
   logic [2*HW-1:0]   prod;
   logic [HW-1:0]     u_ff;
   logic [HW-1:0]     q_ff;
   logic [HW+16:0]    qt_full;
   logic [HW:0]       qt_ff;
   logic [HW:0]       rem;
   logic [HW:0]       rem_fix;

   assign biased  = {{(HW + 1 - lpct_pkg::KEY_W){key[lpct_pkg::KEY_W-1]}}, key}
                    + (HW + 1)'(KEY_BIAS);
   assign prod    = biased[HW-1:0] * RECIP;
   assign qt_full = q_ff * TSIZE;

   always_ff @(posedge clock) begin
      if (cmd.hash_mul) begin
         u_ff <= biased[HW-1:0];
         q_ff <= prod[2*HW-1:HW];
      end
      if (cmd.hash_scale) begin
         qt_ff <= qt_full[HW:0];
      end
   end

   // Quotient estimate is exact or one low, so one correction suffices.
   assign rem     = {1'b0, u_ff} - qt_ff;
   assign rem_fix = (rem >= (HW + 1)'(TABLE_SIZE)) ? rem - (HW + 1)'(TABLE_SIZE) : rem;
   assign slot    = rem_fix[IDX_W-1:0];

endmodule

@@ rtl/lpct_dp.sv @@
// Datapath: request capture, slot memory, probe index and response registers.
module lpct_dp #(
   parameter int unsigned TABLE_SIZE = lpct_pkg::TABLE_SIZE,
   localparam int unsigned IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lpct_pkg::cmd_type                 cmd,
   output lpct_pkg::sts_type                 sts,
   input  logic                              req_mode,
   input  logic signed [lpct_pkg::KEY_W-1:0] req_key,
   output logic [lpct_pkg::COUNT_W-1:0]      rsp_count,
   output logic                              rsp_status
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

   lpct_pkg::slot_type                slot_mem [TABLE_SIZE];
   lpct_pkg::slot_type                rd_ff;
   lpct_pkg::slot_type                wr_data;
   logic                              wr_en;
   logic                              mode_ff;
   logic [lpct_pkg::KEY_W-1:0]        key_ff;
   logic [IDX_W-1:0]                  idx_ff;
   logic [IDX_W-1:0]                  idx_in;
   logic [IDX_W-1:0]                  idx_step;
   logic [IDX_W-1:0]                  probe_ff;
   logic [IDX_W-1:0]                  home;
   logic [lpct_pkg::COUNT_W-1:0]      cnt_bump;
   logic [lpct_pkg::COUNT_W-1:0]      count_ff;
   logic                              status_ff;

   lpct_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
      .clock (clock),
      .cmd   (cmd),
      .key   (key_ff),
      .slot  (home)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
   end

   assign idx_step = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.hash_fold) begin
         idx_in = home;
      end else if (cmd.clr_write || cmd.probe_next) begin
         idx_in = idx_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hash_fold) begin
         probe_ff <= '0;
      end else if (cmd.probe_next) begin
         probe_ff <= probe_ff + 1'b1;
      end
   end

   // Slot memory: one write and one registered read per cycle, same index.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff <= slot_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[idx_ff] <= wr_data;
      end
   end

   // Count zero marks an empty slot; it never matches but ends the probe.
   assign sts.hit        = (rd_ff.count == '0) || (rd_ff.key == key_ff);
   assign sts.probe_last = (probe_ff == IDX_LAST);
   assign sts.clr_last   = (idx_ff == IDX_LAST);

   always_comb begin
      if (rd_ff.count == '0) begin
         cnt_bump = lpct_pkg::COUNT_W'(1);
      end else if (rd_ff.count == lpct_pkg::COUNT_MAX) begin
         cnt_bump = rd_ff.count;
      end else begin
         cnt_bump = rd_ff.count + 1'b1;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_data = '0;
      if (cmd.clr_write) begin
         wr_en = 1'b1;
      end else if (cmd.commit && sts.hit && (mode_ff == lpct_pkg::MODE_INSERT)) begin
         wr_en         = 1'b1;
         wr_data.key   = key_ff;
         wr_data.count = cnt_bump;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (!sts.hit) begin
            count_ff  <= '0;
            status_ff <= lpct_pkg::STATUS_FULL;
         end else begin
            count_ff  <= (mode_ff == lpct_pkg::MODE_INSERT) ? cnt_bump : rd_ff.count;
            status_ff <= lpct_pkg::STATUS_OK;
         end
      end
   end

   assign rsp_count  = count_ff;
   assign rsp_status = status_ff;

endmodule

@@ rtl/lpct_ctrl.sv @@
// Controller: clear pass, request sequencing, probe loop and response handshake.
module lpct_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  lpct_pkg::sts_type sts,
   output lpct_pkg::cmd_type cmd,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_HASH_A = 3'd2;
   localparam logic [2:0] ST_HASH_B = 3'd3;
   localparam logic [2:0] ST_HASH_C = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_CHECK  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_HASH_A;
            end
         end
         ST_HASH_A: begin
            cmd.hash_mul = 1'b1;
            state_in     = ST_HASH_B;
         end
         ST_HASH_B: begin
            cmd.hash_scale = 1'b1;
            state_in       = ST_HASH_C;
         end
         ST_HASH_C: begin
            cmd.hash_fold = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (sts.hit || sts.probe_last) begin
               if (rsp_free) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/linear_probe_count_table.sv @@
// Top level of the linear-probe count table.
//
// Counting hash set of TABLE_SIZE slots with linear probing. Each request
// carries a mode (insert or lookup) and a signed 28-bit key. The home slot is
// (key + 100000000) mod TABLE_SIZE, floored for negative sums; the probe walks
// forward one slot at a time, wrapping at the end, and stops at the first slot
// that is empty (count zero) or holds the key. Insert bumps the count of a
// matching slot, saturating at 65535, or claims the empty slot with count 1,
// and returns the new count. Lookup returns the stored count, 0 if absent.
// If TABLE_SIZE probes find neither, the response is count 0, status 1 (full)
// and nothing changes.
//
// After reset the block runs a clearing pass over all TABLE_SIZE slots of the
// slot memory, one slot per cycle; req_ready stays low until it is done.
//
// Sequencing: one request at a time. From acceptance, the hash unit computes
// the home slot by reciprocal multiply, quotient times table size, then
// remainder fix; each probed slot then takes a registered read of the
// single-port slot memory, then a compare. The response is loaded when the
// probe ends, and the controller returns to idle to take the next request.
// The response sits in an output register, so a new request is accepted
// while the previous response waits on rsp_ready; the probe loop holds its
// final step only if the earlier response is still not taken.
module linear_probe_count_table #(
   parameter int unsigned TABLE_SIZE = lpct_pkg::TABLE_SIZE
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic signed [lpct_pkg::KEY_W-1:0] req_key,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lpct_pkg::COUNT_W-1:0]      rsp_count,
   output logic                              rsp_status
);

   lpct_pkg::cmd_type cmd;
   lpct_pkg::sts_type sts;

   // Sequencer: clear pass, hash steps, probe loop, response handshake.
   lpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   // Slot memory, hash unit, probe index and response data.
   lpct_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

endmodule
